// File: hdl/bb3_pkg.sv
// bb3_pkg: shared constants, types and codes for the 3x3 edge-shrink box filter.
// Used by every module under hdl/; depends on nothing.
`default_nettype none

package bb3_pkg;

    // Image geometry and field widths
    localparam int MAX_WIDTH       = 1024;
    localparam int COL_BITS        = $clog2(MAX_WIDTH);
    localparam int ROW_BITS        = 12;
    localparam int PIX_BITS        = 8;
    localparam int MEAN_BITS       = 16;
    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 12;

    // Config port
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 12;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    // Reset geometry, kept as last index (size - 1)
    localparam logic [COL_BITS-1:0] RESET_WIDTH_LAST  = COL_BITS'(MAX_WIDTH - 1);
    localparam logic [ROW_BITS-1:0] RESET_HEIGHT_LAST = ROW_BITS'(767);

    // Sum of up to nine pixels
    localparam int SUM_BITS = PIX_BITS + 4;

    // Mean = floor(sum * 2^FRAC_BITS / n); n = 6 and n = 9 use a scaled reciprocal
    localparam int FRAC_BITS   = 8;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_BITS  = 22;
    localparam int RECIP_SCALE = 2 ** (FRAC_BITS + RECIP_SHIFT);
    localparam logic [RECIP_BITS-1:0] RECIP6 = RECIP_BITS'((RECIP_SCALE + 5) / 6);
    localparam logic [RECIP_BITS-1:0] RECIP9 = RECIP_BITS'((RECIP_SCALE + 8) / 9);
    localparam int PROD_BITS = SUM_BITS + RECIP_BITS;

    // Stream payload widths
    localparam int IN_TDATA_BITS  = 8;
    localparam int OUT_FIELD_BITS = MEAN_BITS + ROW_BITS + COL_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - OUT_FIELD_BITS;

    // Neighbor count of a result
    typedef enum logic [1:0] {
        DIV4,
        DIV6,
        DIV9
    } t_divisor;

    // Accepted pixel with its clamped coordinates
    typedef struct packed {
        logic [PIX_BITS-1:0] pix;
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic                last_col;
        logic                last_row;
    } t_pix_item;

    // One column of the two line stores: row r-2 (upper) and row r-1 (lower)
    typedef struct packed {
        logic [PIX_BITS-1:0] upper;
        logic [PIX_BITS-1:0] lower;
    } t_line_pair;

    // One result before division
    typedef struct packed {
        logic [SUM_BITS-1:0] sum;
        t_divisor            div;
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic                last;
    } t_job;

endpackage

`default_nettype wire

// File: hdl/box_blur_3x3_edge_shrink_core.sv
// box_blur_3x3_edge_shrink_core: top level of the 3x3 edge-shrink box filter.
// Instantiates bb3_ingest, bb3_line_store, bb3_window and bb3_divide; uses bb3_pkg.
//
// Pixels enter on the s_axis channel in raster order, one item per pixel.
// Each result leaves on the m_axis channel with its mean (8.8, truncated),
// row and column; tlast marks the frame's final result. The config channel
// sets image_width (index 0) and image_height (index 1); write it only while
// the block is idle. o_cfg_ready is always high.
// An item passes the input item register, window, result register and output register to m_axis.
// Results leave at one per cycle through the single divider stage while m_axis is ready: an
// interior item gives one result, so one pixel per cycle is sustained; the
// last pixel of a row gives two results, the last row two per pixel and the
// frame's last pixel four, and s_axis tready drops for the extra cycles.
// The line store is one 1024-entry memory with one read and one write port.
// Reset (synchronous, active low) returns the counters to the frame start,
// clears the window and sets the size to 1024 x 768; line store contents are
// not cleared. When m_axis stalls, every stage holds its item and tready
// falls once the pipeline is full; nothing is dropped.
`default_nettype none

module box_blur_3x3_edge_shrink_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Config write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [bb3_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [bb3_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    // Pixel input
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [bb3_pkg::IN_TDATA_BITS-1:0]    i_s_axis_tdata,  // [7:0] pixel_value
    // Result output
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [bb3_pkg::OUT_TDATA_BITS-1:0]   o_m_axis_tdata,  // [15:0] mean_value,
                                                                  // [27:16] out_row,
                                                                  // [37:28] out_column
    output logic                                 o_m_axis_tlast   // frame_last
);
    import bb3_pkg::*;

    logic                  accept, s2_load, s1_valid;
    logic [COL_BITS-1:0]   rd_col;
    t_pix_item             s1;
    t_line_pair            line_rd;
    logic                  wr_en;
    logic [COL_BITS-1:0]   wr_addr;
    t_line_pair            wr_data;
    logic                  job_valid, job_ready;
    t_job                  job;
    logic [MEAN_BITS-1:0]  mean;
    logic [ROW_BITS-1:0]   out_row;
    logic [COL_BITS-1:0]   out_col;

    assign o_cfg_ready = 1'b1;

    // Counters, config and input item register
    bb3_ingest u_ingest (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_axis_tvalid),
        .i_pix       (i_s_axis_tdata[PIX_BITS-1:0]),
        .o_ready     (o_s_axis_tready),
        .i_s2_load   (s2_load),
        .o_accept    (accept),
        .o_rd_col    (rd_col),
        .o_s1_valid  (s1_valid),
        .o_s1        (s1)
    );

    // Rows r-2 and r-1
    bb3_line_store u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (rd_col),
        .o_rd_data (line_rd),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // Window and per-result sums
    bb3_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1_valid  (s1_valid),
        .i_s1        (s1),
        .i_line      (line_rd),
        .o_s2_load   (s2_load),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_ready (job_ready)
    );

    // Division and output register
    bb3_divide u_divide (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_ready (job_ready),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_mean      (mean),
        .o_row       (out_row),
        .o_col       (out_col),
        .o_last      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {{OUT_PAD_BITS{1'b0}}, out_col, out_row, mean};

endmodule

`default_nettype wire

// File: hdl/bb3_line_store.sv
// bb3_line_store: the two line stores, kept side by side in one memory word.
// One registered read and one write per cycle. Uses bb3_pkg.
`default_nettype none

module bb3_line_store (
    input  logic                             i_clk,
    input  logic                             i_rd_en,
    input  logic [bb3_pkg::COL_BITS-1:0]     i_rd_addr,
    output bb3_pkg::t_line_pair              o_rd_data,
    input  logic                             i_wr_en,
    input  logic [bb3_pkg::COL_BITS-1:0]     i_wr_addr,
    input  bb3_pkg::t_line_pair              i_wr_data
);
    import bb3_pkg::*;

    t_line_pair r_mem [MAX_WIDTH];
    t_line_pair r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, held while no new item is accepted
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: hdl/bb3_ingest.sv
// bb3_ingest: config registers, row/column counters and the input item register.
// Clamps coordinates to the image size in use. Uses bb3_pkg.
`default_nettype none

module bb3_ingest (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [bb3_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [bb3_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                                i_valid,
    input  logic [bb3_pkg::PIX_BITS-1:0]        i_pix,
    output logic                                o_ready,
    input  logic                                i_s2_load,
    output logic                                o_accept,
    output logic [bb3_pkg::COL_BITS-1:0]        o_rd_col,
    output logic                                o_s1_valid,
    output bb3_pkg::t_pix_item                  o_s1
);
    import bb3_pkg::*;

    logic [COL_BITS-1:0]       r_w_last, n_w_last;
    logic [ROW_BITS-1:0]       r_h_last, n_h_last;
    logic [ROW_BITS-1:0]       r_row, n_row;
    logic [COL_BITS-1:0]       r_col, n_col;
    logic                      r_s1_valid;
    t_pix_item                 r_s1;
    logic [WIDTH_REG_BITS-1:0] wv;
    logic [ROW_BITS-1:0]       hv;
    logic                      accept;
    logic                      last_col, last_row;
    logic [COL_BITS-1:0]       col_cl;
    logic [ROW_BITS-1:0]       row_cl;

    // Size registers hold the clamped last index
    always_comb begin
        wv = i_cfg_data[WIDTH_REG_BITS-1:0];
        hv = i_cfg_data[HEIGHT_REG_BITS-1:0];
        if (wv < WIDTH_REG_BITS'(2)) begin
            n_w_last = COL_BITS'(1);
        end else if (wv > WIDTH_REG_BITS'(MAX_WIDTH)) begin
            n_w_last = COL_BITS'(MAX_WIDTH - 1);
        end else begin
            n_w_last = COL_BITS'(wv - WIDTH_REG_BITS'(1));
        end
        if (hv < ROW_BITS'(2)) begin
            n_h_last = ROW_BITS'(1);
        end else begin
            n_h_last = hv - ROW_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= RESET_WIDTH_LAST;
            r_h_last <= RESET_HEIGHT_LAST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_w_last <= n_w_last;
                CFG_IMAGE_HEIGHT: r_h_last <= n_h_last;
                default: ;
            endcase
        end
    end

    // Clamp counters; a counter at or past the last index counts as last
    assign last_col = (r_col >= r_w_last);
    assign last_row = (r_row >= r_h_last);
    assign col_cl   = last_col ? r_w_last : r_col;
    assign row_cl   = last_row ? r_h_last : r_row;

    assign o_ready  = !r_s1_valid || i_s2_load;
    assign accept   = i_valid && o_ready;
    assign o_accept = accept;
    assign o_rd_col = col_cl;

    // Raster counters
    always_comb begin
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : row_cl + ROW_BITS'(1);
        end else begin
            n_col = col_cl + COL_BITS'(1);
            n_row = row_cl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // Input item register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (i_s2_load) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.pix      <= i_pix;
            r_s1.row      <= row_cl;
            r_s1.col      <= col_cl;
            r_s1.last_col <= last_col;
            r_s1.last_row <= last_row;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

    // A held item stays put until the window takes it
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !i_s2_load) |=> (r_s1_valid && $stable(r_s1)))
        else $error("input item lost before the window took it");

    // The frame's last pixel wraps both counters
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last_col && last_row) |=> (r_row == '0 && r_col == '0))
        else $error("counters did not wrap after the last pixel");

endmodule

`default_nettype wire

// File: hdl/bb3_window.sv
// bb3_window: 3x3 window register, pending-result mask and the per-result
// neighbor sum. Emits one summed result per cycle while the divider takes them. Uses bb3_pkg.
`default_nettype none

module bb3_window (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s1_valid,
    input  bb3_pkg::t_pix_item               i_s1,
    input  bb3_pkg::t_line_pair              i_line,
    output logic                             o_s2_load,
    output logic                             o_wr_en,
    output logic [bb3_pkg::COL_BITS-1:0]     o_wr_addr,
    output bb3_pkg::t_line_pair              o_wr_data,
    output logic                             o_job_valid,
    output bb3_pkg::t_job                    o_job,
    input  logic                             i_job_ready
);
    import bb3_pkg::*;

    // Pending result slots, in output order
    localparam int RES_UP_LEFT = 0;  // (r-1, c-1)
    localparam int RES_UP      = 1;  // (r-1, c), last column
    localparam int RES_LEFT    = 2;  // (r, c-1), last row
    localparam int RES_HERE    = 3;  // (r, c), last pixel of the frame

    logic [PIX_BITS-1:0] r_win [3][3];
    logic [ROW_BITS-1:0] r_row;
    logic [COL_BITS-1:0] r_col;
    logic                r_row_ge2, r_col_ge2;
    logic [3:0]          r_pend, n_pend, new_pend, pick;
    logic                r_job_valid;
    t_job                r_job, n_job;
    logic                job_ready, take, s2_load, single;
    logic [2:0]          row_mask, col_mask;
    logic [SUM_BITS-1:0] sum;

    assign job_ready = !r_job_valid || i_job_ready;
    assign take      = (r_pend != '0) && job_ready;
    assign pick      = r_pend & (~r_pend + 4'd1);
    assign single    = (r_pend & (r_pend - 4'd1)) == '0;
    assign s2_load   = i_s1_valid && ((r_pend == '0) || (take && single));
    assign o_s2_load = s2_load;

    // Results released by the new item
    always_comb begin
        new_pend              = '0;
        new_pend[RES_UP_LEFT] = (i_s1.row != '0) && (i_s1.col != '0);
        new_pend[RES_UP]      = (i_s1.row != '0) && i_s1.last_col;
        new_pend[RES_LEFT]    = i_s1.last_row && (i_s1.col != '0);
        new_pend[RES_HERE]    = i_s1.last_row && i_s1.last_col;
    end

    always_comb begin
        if (s2_load) begin
            n_pend = new_pend;
        end else if (take) begin
            n_pend = r_pend & ~pick;
        end else begin
            n_pend = r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    // Window shift and line store update on each new item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (s2_load) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= i_line.upper;
            r_win[1][2] <= i_line.lower;
            r_win[2][2] <= i_s1.pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_row     <= i_s1.row;
            r_col     <= i_s1.col;
            r_row_ge2 <= i_s1.row >= ROW_BITS'(2);
            r_col_ge2 <= i_s1.col >= COL_BITS'(2);
        end
    end

    assign o_wr_en         = s2_load;
    assign o_wr_addr       = i_s1.col;
    assign o_wr_data.upper = i_line.lower;
    assign o_wr_data.lower = i_s1.pix;

    // Neighbors of the selected result; window row/col 0 is the oldest
    always_comb begin
        row_mask  = 3'b110;
        col_mask  = 3'b110;
        n_job.row = r_row;
        n_job.col = r_col;
        n_job.last = 1'b0;
        if (pick[RES_UP_LEFT]) begin
            row_mask  = {2'b11, r_row_ge2};
            col_mask  = {2'b11, r_col_ge2};
            n_job.row = r_row - ROW_BITS'(1);
            n_job.col = r_col - COL_BITS'(1);
        end else if (pick[RES_UP]) begin
            row_mask  = {2'b11, r_row_ge2};
            n_job.row = r_row - ROW_BITS'(1);
        end else if (pick[RES_LEFT]) begin
            col_mask  = {2'b11, r_col_ge2};
            n_job.col = r_col - COL_BITS'(1);
        end else begin
            n_job.last = 1'b1;
        end

        sum = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (row_mask[i] && col_mask[j]) begin
                    sum = sum + SUM_BITS'(r_win[i][j]);
                end
            end
        end
        n_job.sum = sum;

        if (row_mask[0] && col_mask[0]) begin
            n_job.div = DIV9;
        end else if (row_mask[0] || col_mask[0]) begin
            n_job.div = DIV6;
        end else begin
            n_job.div = DIV4;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
        end else if (take) begin
            r_job_valid <= 1'b1;
        end else if (i_job_ready) begin
            r_job_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job <= n_job;
        end
    end

    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;

    // The frame's final result is a corner
    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_job_valid && r_job.last) |-> (r_job.div == DIV4))
        else $error("final result without corner divisor");

    // The final result goes out after every other result of its item
    a_last_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && pick[RES_HERE]) |-> (r_pend == 4'b1000))
        else $error("final result taken ahead of pending results");

endmodule

`default_nettype wire

// File: hdl/bb3_divide.sv
// bb3_divide: divides a neighbor sum by 4, 6 or 9 into 8.8 fixed point and
// holds the output register. Uses bb3_pkg.
`default_nettype none

module bb3_divide (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_job_valid,
    input  bb3_pkg::t_job                    i_job,
    output logic                             o_job_ready,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [bb3_pkg::MEAN_BITS-1:0]    o_mean,
    output logic [bb3_pkg::ROW_BITS-1:0]     o_row,
    output logic [bb3_pkg::COL_BITS-1:0]     o_col,
    output logic                             o_last
);
    import bb3_pkg::*;

    logic                   r_valid;
    logic [MEAN_BITS-1:0]   r_mean, n_mean;
    logic [ROW_BITS-1:0]    r_row;
    logic [COL_BITS-1:0]    r_col;
    logic                   r_last;
    logic [RECIP_BITS-1:0]  recip;
    logic [PROD_BITS-1:0]   prod;
    logic                   load;

    assign o_job_ready = !r_valid || i_ready;
    assign load        = i_job_valid && o_job_ready;

    // Divide by 4 is a shift; 6 and 9 multiply by a rounded-up reciprocal
    always_comb begin
        case (i_job.div)
            DIV6:    recip = RECIP6;
            default: recip = RECIP9;
        endcase
        prod = PROD_BITS'(i_job.sum) * PROD_BITS'(recip);
        case (i_job.div)
            DIV4:    n_mean = MEAN_BITS'({i_job.sum, {(FRAC_BITS - 2){1'b0}}});
            default: n_mean = prod[RECIP_SHIFT +: MEAN_BITS];
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_mean <= n_mean;
            r_row  <= i_job.row;
            r_col  <= i_job.col;
            r_last <= i_job.last;
        end
    end

    assign o_valid = r_valid;
    assign o_mean  = r_mean;
    assign o_row   = r_row;
    assign o_col   = r_col;
    assign o_last  = r_last;

    // A mean of 8-bit pixels never exceeds 255.0
    a_mean_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_mean <= MEAN_BITS'(16'hFF00)))
        else $error("mean out of range");

endmodule

`default_nettype wire
